>>> rtl/core/raw_block_pixel_unpacker_assert.svh
// Assertion shorthands for the raw block pixel unpacker.
`ifndef RAW_BLOCK_PIXEL_UNPACKER_ASSERT_SVH
`define RAW_BLOCK_PIXEL_UNPACKER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define RBPU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define RBPU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rbpu_pkg.sv
`default_nettype none

package rbpu_pkg;

    // Stream widths
    localparam int WORD_W  = 32;
    localparam int PIX_W   = 16;
    localparam int BLOCK_W = 128;

    // Block layout
    localparam int FIRST_BITS = 14;
    localparam int REST_BITS  = 10;
    localparam int CODE_BITS  = 2;
    localparam int GROUP_BITS = CODE_BITS + REST_BITS;
    localparam int PIX_IDX_W  = 4;

    localparam logic [PIX_IDX_W-1:0] LAST_PIX = 4'd10;
    localparam logic [PIX_IDX_W-1:0] GROUP0   = 4'd2;
    localparam logic [PIX_IDX_W-1:0] GROUP1   = 4'd5;
    localparam logic [PIX_IDX_W-1:0] GROUP2   = 4'd8;

    // Words held before the closing word of a block
    localparam logic [1:0] LAST_WORD = 2'd3;

    // Scale and offset constants
    localparam logic [CODE_BITS-1:0] CODE_WIDE  = 2'd3;
    localparam logic [2:0]           SHIFT_WIDE = 3'd4;
    localparam logic [PIX_W-1:0]     BASE_UNIT  = 16'h0200;
    localparam logic [PIX_W-1:0]     BASE_LIMIT = 16'h2000;
    localparam logic [PIX_W-1:0]     BLACK_OFS  = 16'h000f;

    // Default depth of the block queue
    localparam int QUEUE_DEPTH_DEF = 2;

    // Block handed from front to queue
    typedef struct packed {
        logic               valid;
        logic [BLOCK_W-1:0] data;
    } push_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

    // Back status
    typedef struct packed {
        logic busy;
        logic pop;
    } back_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/raw_block_pixel_unpacker.sv
// Raw block pixel unpacker.
// Input stream (s_*): one 32-bit compressed word per transaction, in file
// order; every four words form one 128-bit block, the fourth word on top.
// Output stream (m_*): eleven 16-bit pixels per block, black offset removed
// and clamped at zero; m_tlast marks the eleventh pixel.
// The front takes one word per cycle, except that it stalls on the closing
// word while the queue is full, and pushes each complete block into a small
// block queue (QUEUE_DEPTH entries); the back decodes one pixel per cycle
// from the head of the queue while the receiver accepts them, and loads a
// new block only after the last pixel of the current one, so the queue
// lets the front take the next block meanwhile and absorbs short bursts at
// one word per cycle.
// Receiver stall: the output register holds its pixel, the back stops, the
// queue fills, and s_tready drops on the closing word of a block once the
// queue is full.
// Reset (aresetn low, synchronous): the queue, word count and decode state
// clear; any partial block is dropped.
`default_nettype none
`include "raw_block_pixel_unpacker_assert.svh"

module raw_block_pixel_unpacker #(
    parameter int QUEUE_DEPTH = rbpu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [rbpu_pkg::WORD_W-1:0] s_tdata,   // [31:0] data_word
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [rbpu_pkg::PIX_W-1:0]       m_tdata,   // [15:0] pixel_value
    output logic                             m_tlast    // last_of_block
);

    rbpu_pkg::push_t                 push;
    rbpu_pkg::q_stat_t               q_stat;
    rbpu_pkg::back_stat_t            back_stat;
    logic [rbpu_pkg::BLOCK_W-1:0]    q_data;

    rbpu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .push     (push)
    );

    rbpu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (back_stat.pop),
        .rd_data (q_data),
        .q_stat  (q_stat)
    );

    rbpu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .q_data    (q_data),
        .back_stat (back_stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Check queue flow control and back sequencing
    `RBPU_ASSERT_NOW(a_push_room, aclk, aresetn, push.valid, !q_stat.full, "block pushed into full queue")
    `RBPU_ASSERT_NOW(a_stall_full, aclk, aresetn, !s_tready, q_stat.full, "input stalled with queue room")
    `RBPU_ASSERT_NOW(a_pop_idle, aclk, aresetn, back_stat.pop, !back_stat.busy, "block loaded while busy")
    `RBPU_ASSERT_NEXT(a_pop_busy, aclk, aresetn, back_stat.pop, back_stat.busy, "back idle after load")

endmodule

`default_nettype wire

>>> rtl/core/rbpu_front.sv
`default_nettype none

module rbpu_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [rbpu_pkg::WORD_W-1:0] s_tdata,   // [31:0] data_word
    input  wire rbpu_pkg::q_stat_t          q_stat,
    output rbpu_pkg::push_t                 push
);

    logic [1:0]                  word_count_reg;
    logic [1:0]                  word_count_next;
    logic [rbpu_pkg::WORD_W-1:0] word_store_reg [3];
    logic                        accept;
    logic                        closing;

    // Stall only on the closing word while the queue is full
    assign closing  = (word_count_reg == rbpu_pkg::LAST_WORD);
    assign s_tready = !closing || !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    // Assemble the block, last word on top
    assign push.valid = accept && closing;
    assign push.data  = {s_tdata, word_store_reg[2], word_store_reg[1], word_store_reg[0]};

    always_comb begin
        word_count_next = word_count_reg;
        if (accept) begin
            word_count_next = closing ? 2'd0 : word_count_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_count_reg <= 2'd0;
        end else begin
            word_count_reg <= word_count_next;
        end
    end

    // Hold the leading words of the block
    always_ff @(posedge aclk) begin
        if (accept && !closing) begin
            word_store_reg[word_count_reg] <= s_tdata;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rbpu_queue.sv
`default_nettype none

module rbpu_queue #(
    parameter int DEPTH = rbpu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire rbpu_pkg::push_t             push,
    input  wire logic                        pop,
    output logic [rbpu_pkg::BLOCK_W-1:0]     rd_data,
    output rbpu_pkg::q_stat_t                q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [rbpu_pkg::BLOCK_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]             wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]             rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         do_pop;

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.valid = (count_reg != '0);
    assign rd_data      = entry_reg[rd_ptr_reg];
    assign do_pop       = pop && q_stat.valid;

    // Advance pointers with wrap and track the entry count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push.valid && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push.valid && do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store an incoming block
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entry_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rbpu_back.sv
`default_nettype none

module rbpu_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire rbpu_pkg::q_stat_t            q_stat,
    input  wire logic [rbpu_pkg::BLOCK_W-1:0] q_data,
    output rbpu_pkg::back_stat_t              back_stat,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [rbpu_pkg::PIX_W-1:0]        m_tdata,   // [15:0] pixel_value
    output logic                              m_tlast    // last_of_block
);

    localparam int PW = rbpu_pkg::PIX_W;
    localparam int BW = rbpu_pkg::BLOCK_W;
    localparam int CB = rbpu_pkg::CODE_BITS;

    // Map a scale code to its shift
    function automatic logic [2:0] code_shift(input logic [CB-1:0] code);
        logic [2:0] s;
        s = (code == rbpu_pkg::CODE_WIDE) ? rbpu_pkg::SHIFT_WIDE : {1'b0, code};
        return s;
    endfunction

    logic                              busy_reg, busy_next;
    logic [BW-1:0]                     win_reg, win_next;
    logic [rbpu_pkg::PIX_IDX_W-1:0]    pix_reg, pix_next;
    logic [2:0]                        shift_reg, shift_next;
    logic [1:0]                        first_nz_reg, first_nz_next;
    logic [PW-1:0]                     ref_reg [2];
    logic [PW-1:0]                     ref_next [2];
    logic                              out_valid_reg, out_valid_next;
    logic [PW-1:0]                     out_pix_reg, out_pix_next;
    logic                              out_last_reg, out_last_next;

    logic          load;
    logic          advance;
    logic          is_raw;
    logic          is_grp;
    logic          par;
    logic          last_pix;
    logic [2:0]    shift_now;
    logic [PW-1:0] v_in;
    logic [PW-1:0] scaled;
    logic [PW-1:0] base;
    logic [PW-1:0] ref_cur;
    logic [PW-1:0] v_out;
    logic [PW-1:0] res;

    assign load    = !busy_reg && q_stat.valid;
    assign advance = busy_reg && (!out_valid_reg || m_tready);

    assign back_stat.busy = busy_reg;
    assign back_stat.pop  = load;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;

    // Classify the current pixel position
    assign is_raw   = (pix_reg[rbpu_pkg::PIX_IDX_W-1:1] == '0);
    assign is_grp   = (pix_reg == rbpu_pkg::GROUP0) || (pix_reg == rbpu_pkg::GROUP1) ||
                      (pix_reg == rbpu_pkg::GROUP2);
    assign last_pix = (pix_reg == rbpu_pkg::LAST_PIX);
    assign par      = pix_reg[0];

    // Pull the fields from the top of the window
    assign shift_now = is_grp ? code_shift(win_reg[BW-1 -: CB]) : shift_reg;

    always_comb begin
        if (is_raw) begin
            v_in = PW'(win_reg[BW-1 -: rbpu_pkg::FIRST_BITS]);
        end else if (is_grp) begin
            v_in = PW'(win_reg[BW-1-CB -: rbpu_pkg::REST_BITS]);
        end else begin
            v_in = PW'(win_reg[BW-1 -: rbpu_pkg::REST_BITS]);
        end
    end

    // Scale and add the running reference
    assign ref_cur = ref_reg[par];
    assign base    = rbpu_pkg::BASE_UNIT << shift_now;
    assign scaled  = v_in << shift_now;

    always_comb begin
        first_nz_next = first_nz_reg;
        ref_next[0]   = ref_reg[0];
        ref_next[1]   = ref_reg[1];
        if (first_nz_reg[par]) begin
            if ((base < rbpu_pkg::BASE_LIMIT) && (ref_cur > base)) begin
                v_out = scaled + (ref_cur - base);
            end else begin
                v_out = scaled;
            end
            ref_next[par] = v_out;
        end else begin
            first_nz_next[par] = (v_in != '0);
            if (v_in != '0) begin
                v_out         = v_in;
                ref_next[par] = v_in;
            end else begin
                v_out = ref_cur;
            end
        end
    end

    // Remove the black offset, clamp at zero
    assign res = (v_out >= rbpu_pkg::BLACK_OFS) ? v_out - rbpu_pkg::BLACK_OFS : '0;

    // Sequence the block and the output register
    always_comb begin
        busy_next      = busy_reg;
        win_next       = win_reg;
        pix_next       = pix_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        out_last_next  = out_last_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (load) begin
            busy_next  = 1'b1;
            win_next   = q_data;
            pix_next   = '0;
            shift_next = '0;
        end else if (advance) begin
            out_valid_next = 1'b1;
            out_pix_next   = res;
            out_last_next  = last_pix;
            pix_next       = pix_reg + rbpu_pkg::PIX_IDX_W'(1);
            busy_next      = !last_pix;
            if (is_grp) begin
                shift_next = shift_now;
            end
            if (is_raw) begin
                win_next = win_reg << rbpu_pkg::FIRST_BITS;
            end else if (is_grp) begin
                win_next = win_reg << rbpu_pkg::GROUP_BITS;
            end else begin
                win_next = win_reg << rbpu_pkg::REST_BITS;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pix_reg       <= '0;
            shift_reg     <= '0;
            first_nz_reg  <= '0;
            ref_reg[0]    <= '0;
            ref_reg[1]    <= '0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            pix_reg       <= pix_next;
            shift_reg     <= shift_next;
            if (load) begin
                first_nz_reg <= '0;
                ref_reg[0]   <= '0;
                ref_reg[1]   <= '0;
            end else if (advance) begin
                first_nz_reg <= first_nz_next;
                ref_reg[0]   <= ref_next[0];
                ref_reg[1]   <= ref_next[1];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        win_reg      <= win_next;
        out_pix_reg  <= out_pix_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire
